### rtl/btff_pkg.sv
// btff_pkg: constants, opcodes and sequencer states of the boundary-tag allocator
// no dependencies
package btff_pkg;

  localparam int HEAP_WORDS = 4096;
  localparam int WORD_BYTES = 8;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int TAG_W      = 16;
  localparam int OFF_W      = 17;
  localparam int MEM_BYTES  = HEAP_WORDS * WORD_BYTES;
  localparam int SPLIT_MIN  = 3 * WORD_BYTES;
  localparam int TAG_PAIR   = 2 * WORD_BYTES;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_A_RD,
    S_A_CHK,
    S_A_APP,
    S_F_HB,
    S_F_HF,
    S_F_PF,
    S_F_PH,
    S_F_NX,
    S_F_NH,
    S_F_MRG,
    S_WR,
    S_RESP
  } state_t;

  localparam logic REG_HEAP_LIMIT = 1'b0;

endpackage

### rtl/boundary_tag_first_fit_allocator_top.sv
// boundary_tag_first_fit_allocator_top: heap allocator over a tag memory with first-fit walk
// depends on btff_pkg
//
//   channel   signals                                  direction
//   request   start, busy, op, request_size, block_addr  in (busy out)
//   result    done, payload_addr, status              out
//   config    psel penable pwrite paddr pwdata prdata pready  apb
//
// allocate: each block walked takes a tag read, then a check; a fit adds 2 or 4 tag writes
//   and a result; append goes through the end of heap, then the limit check, plus
//   2 writes. free: reads the block and neighbour tags, merges, then 2 or 4 writes
// clear and reset: a sweep of all 4096 words of the tag memory, one word a cycle
// the tag memory serves one read or one write at a time; one request at a time
// a result sits on the ports for one cycle with done high and cannot be held off
module boundary_tag_first_fit_allocator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   op,
  input  logic [14:0]                  request_size,
  input  logic [14:0]                  block_addr,
  output logic                         done,
  output logic [14:0]                  payload_addr,
  output logic                         status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import btff_pkg::*;

  state_t state, state_next;

  logic [TAG_W-1:0] mem [HEAP_WORDS];
  logic [TAG_W-1:0] rdata;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [TAG_W-1:0] wr_data;

  logic [15:0]      heap_end, heap_limit;
  logic [OFF_W-1:0] p, fpos, pp, nf;
  logic [15:0]      a, s, psz, nsz;
  logic [14:0]      b;
  logic             mprev, mnext;
  logic [OFF_W-1:0] wq_addr [4];
  logic [TAG_W-1:0] wq_data [4];
  logic [2:0]       wq_cnt;
  logic [1:0]       wi;
  logic [IDX_W-1:0] clr_idx;
  logic             clr_resp;
  logic [14:0]      res_addr;
  logic             res_status;

  function automatic logic [IDX_W-1:0] off_idx(input logic [OFF_W-1:0] off);
    return off[IDX_W+2:3];
  endfunction

  logic [15:0]      rsize, a_round, rest, tot_both, tot_prev, tot_next;
  logic [OFF_W-1:0] he_x, cap_x, fpos_c, p_step, pp_c, n_c, nf_c, need, q, b_x;
  logic             a_fit, split, pf_ok, app_ok, addr_ok, cfg_wr;

  assign rsize    = {rdata[15:3], 3'b000};
  assign a_round  = ({1'b0, request_size} + 16'd7) & 16'hFFF8;
  assign he_x     = {1'b0, heap_end};
  assign cap_x    = (heap_limit < 16'(MEM_BYTES)) ? {1'b0, heap_limit} : OFF_W'(MEM_BYTES);
  assign b_x      = {2'b00, b};
  assign fpos_c   = b_x + {1'b0, rsize} + OFF_W'(WORD_BYTES);
  assign p_step   = p + {1'b0, rsize} + OFF_W'(TAG_PAIR);
  assign a_fit    = !rdata[0] && (rsize >= a);
  assign split    = (rsize - a) >= 16'(SPLIT_MIN);
  assign rest     = rsize - a - 16'(TAG_PAIR);
  assign q        = p + {1'b0, a} + OFF_W'(TAG_PAIR);
  assign pf_ok    = ({1'b0, rsize} + OFF_W'(TAG_PAIR)) <= b_x;
  assign pp_c     = b_x - {1'b0, rsize} - OFF_W'(TAG_PAIR);
  assign n_c      = b_x + {1'b0, s} + OFF_W'(TAG_PAIR);
  assign nf_c     = n_c + {1'b0, rsize} + OFF_W'(WORD_BYTES);
  assign need     = {1'b0, a} + OFF_W'(TAG_PAIR);
  assign app_ok   = (he_x + need) <= cap_x;
  assign addr_ok  = (block_addr[2:0] == 3'd0) && (block_addr >= 15'(WORD_BYTES)) &&
                    ({2'b00, block_addr - 15'(WORD_BYTES)} < he_x);
  assign tot_both = s + psz + nsz + 16'(2 * TAG_PAIR);
  assign tot_prev = s + psz + 16'(TAG_PAIR);
  assign tot_next = s + nsz + 16'(TAG_PAIR);

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? {16'd0, heap_limit} : 32'd0;

  assign busy         = (state != S_IDLE);
  assign done         = (state == S_RESP);
  assign payload_addr = done ? res_addr : 15'd0;
  assign status       = done && res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_idx     = '0;
    wr_en      = 1'b0;
    wr_idx     = '0;
    wr_data    = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_ALLOC: state_next = S_A_RD;
            OP_FREE: begin
              if (addr_ok) begin
                rd_en      = 1'b1;
                rd_idx     = off_idx({2'b00, block_addr - 15'(WORD_BYTES)});
                state_next = S_F_HB;
              end else begin
                state_next = S_RESP;
              end
            end
            OP_CLEAR: state_next = S_CLR;
            default:  state_next = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        wr_en  = 1'b1;
        wr_idx = clr_idx;
        if (clr_idx == IDX_W'(HEAP_WORDS - 1)) begin
          state_next = clr_resp ? S_RESP : S_IDLE;
        end
      end
      S_A_RD: begin
        if (p >= he_x) begin
          state_next = S_A_APP;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = off_idx(p);
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: state_next = a_fit ? S_WR : S_A_RD;
      S_A_APP: state_next = app_ok ? S_WR : S_RESP;
      S_F_HB: begin
        if (fpos_c >= he_x) begin
          state_next = S_RESP;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = off_idx(fpos_c);
          state_next = S_F_HF;
        end
      end
      S_F_HF: begin
        if (b >= 15'(TAG_PAIR)) begin
          rd_en      = 1'b1;
          rd_idx     = off_idx(b_x - OFF_W'(WORD_BYTES));
          state_next = S_F_PF;
        end else begin
          state_next = S_F_NX;
        end
      end
      S_F_PF: begin
        if (pf_ok) begin
          rd_en      = 1'b1;
          rd_idx     = off_idx(pp_c);
          state_next = S_F_PH;
        end else begin
          state_next = S_F_NX;
        end
      end
      S_F_PH: state_next = S_F_NX;
      S_F_NX: begin
        if (n_c < he_x) begin
          rd_en      = 1'b1;
          rd_idx     = off_idx(n_c);
          state_next = S_F_NH;
        end else begin
          state_next = S_F_MRG;
        end
      end
      S_F_NH:  state_next = S_F_MRG;
      S_F_MRG: state_next = S_WR;
      S_WR: begin
        // writes past the memory are dropped
        wr_en   = (wq_addr[wi][OFF_W-1:IDX_W+3] == '0);
        wr_idx  = off_idx(wq_addr[wi]);
        wr_data = wq_data[wi];
        if ({1'b0, wi} == wq_cnt - 3'd1) begin
          state_next = S_RESP;
        end
      end
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_end   <= '0;
      heap_limit <= 16'h8000;
      clr_idx    <= '0;
      clr_resp   <= 1'b0;
      wq_cnt     <= '0;
      wi         <= '0;
    end else begin
      if (cfg_wr && paddr[2] == REG_HEAP_LIMIT) begin
        heap_limit <= pwdata[15:0];
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            res_addr   <= '0;
            res_status <= 1'b0;
            a          <= a_round;
            p          <= '0;
            b          <= block_addr - 15'(WORD_BYTES);
            mprev      <= 1'b0;
            mnext      <= 1'b0;
            wi         <= '0;
            if (op == OP_CLEAR) begin
              clr_resp <= 1'b1;
              clr_idx  <= '0;
              heap_end <= '0;
            end
          end
        end
        S_CLR: clr_idx <= clr_idx + 1'b1;
        S_A_CHK: begin
          if (a_fit) begin
            res_addr   <= 15'(p + OFF_W'(WORD_BYTES));
            wq_addr[0] <= p;
            if (split) begin
              wq_data[0] <= a | 16'h1;
              wq_addr[1] <= p + {1'b0, a} + OFF_W'(WORD_BYTES);
              wq_data[1] <= a | 16'h1;
              wq_addr[2] <= q;
              wq_data[2] <= rest;
              wq_addr[3] <= q + {1'b0, rest} + OFF_W'(WORD_BYTES);
              wq_data[3] <= rest;
              wq_cnt     <= 3'd4;
            end else begin
              wq_data[0] <= rsize | 16'h1;
              wq_addr[1] <= p + {1'b0, rsize} + OFF_W'(WORD_BYTES);
              wq_data[1] <= rsize | 16'h1;
              wq_cnt     <= 3'd2;
            end
          end else begin
            p <= p_step;
          end
        end
        S_A_APP: begin
          if (app_ok) begin
            res_addr   <= 15'(he_x + OFF_W'(WORD_BYTES));
            wq_addr[0] <= he_x;
            wq_data[0] <= a | 16'h1;
            wq_addr[1] <= he_x + {1'b0, a} + OFF_W'(WORD_BYTES);
            wq_data[1] <= a | 16'h1;
            wq_cnt     <= 3'd2;
            heap_end   <= heap_end + need[15:0];
          end else begin
            res_status <= 1'b1;
          end
        end
        S_F_HB: begin
          s          <= rsize;
          fpos       <= fpos_c;
          wq_addr[0] <= b_x;
          wq_data[0] <= rdata & 16'hFFFE;
        end
        S_F_HF: begin
          wq_addr[1] <= fpos;
          wq_data[1] <= rdata & 16'hFFFE;
          wq_cnt     <= 3'd2;
        end
        S_F_PF: pp <= pp_c;
        S_F_PH: begin
          if (!rdata[0]) begin
            mprev <= 1'b1;
            psz   <= rsize;
          end
        end
        S_F_NH: begin
          if (!rdata[0]) begin
            nsz   <= rsize;
            nf    <= nf_c;
            mnext <= (nf_c < he_x);
          end
        end
        S_F_MRG: begin
          priority if (mprev && mnext) begin
            wq_addr[2] <= pp;
            wq_data[2] <= tot_both;
            wq_addr[3] <= nf;
            wq_data[3] <= tot_both;
            wq_cnt     <= 3'd4;
          end else if (mprev) begin
            wq_addr[2] <= pp;
            wq_data[2] <= tot_prev;
            wq_addr[3] <= fpos;
            wq_data[3] <= tot_prev;
            wq_cnt     <= 3'd4;
          end else if (mnext) begin
            wq_addr[2] <= b_x;
            wq_data[2] <= tot_next;
            wq_addr[3] <= nf;
            wq_data[3] <= tot_next;
            wq_cnt     <= 3'd4;
          end
        end
        S_WR:   wi <= wi + 1'b1;
        S_RESP: clr_resp <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_take_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request taken without going busy");
  a_heap_end: assert property (@(posedge clk) disable iff (rst)
      (heap_end <= 16'(MEM_BYTES)) && (heap_end[2:0] == 3'd0))
    else $error("heap end out of range or unaligned");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
      status |-> (done && payload_addr == 15'd0))
    else $error("failed allocate returned an address");

endmodule
